// File: hdl/dmsr_pkg.sv
// Shared types and constants for the dense mask to sparse rows converter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dmsr_pkg;

  localparam int ROW_BITS = 32;   // width of one row mask
  localparam int IDX_W    = 5;    // column index bits
  localparam int CNT_W    = 6;    // counts up to ROW_BITS
  localparam int PORT_OFF_W = 16; // offset and total fields on the result port

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_EMIT    = 2'd2;

  localparam logic REG_LAYOUT  = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  localparam logic LAYOUT_CRS    = 1'b0;
  localparam logic LAYOUT_ITPACK = 1'b1;

  localparam logic [CNT_W-1:0] COLUMNS_RESET = 6'd32;
  localparam logic [CNT_W-1:0] NEG_ONE       = 6'h3F;

  typedef struct packed {
    logic load;     // take a new row and column limit, restart at column 0
    logic restart;  // rescan the held row from column 0
    logic step;     // advance one column
  } scan_ctl_t;

  typedef struct packed {
    logic             hit;   // current column is active
    logic             done;  // column limit reached
    logic [IDX_W-1:0] col;
  } scan_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0]      col_index;
    logic [CNT_W-1:0]      row_count;
    logic [PORT_OFF_W-1:0] row_end_offset;
    logic [CNT_W-1:0]      max_width;
    logic [PORT_OFF_W-1:0] total_entries;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/dmsr_in_if.sv
// Row input channel: op code and row mask with valid/ready.
// Depends on dmsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dmsr_in_if;
  import dmsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [ROW_BITS-1:0] row_mask;

  modport source (output valid, output op, output row_mask, input ready);
  modport sink   (input valid, input op, input row_mask, output ready);
endinterface

`default_nettype wire

// File: hdl/dmsr_out_if.sv
// Result channel: one sparse entry or counter report per beat.
// Depends on dmsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dmsr_out_if;
  import dmsr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [CNT_W-1:0] col_index;
  logic [CNT_W-1:0]      row_count;
  logic [PORT_OFF_W-1:0] row_end_offset;
  logic [CNT_W-1:0]      max_width;
  logic [PORT_OFF_W-1:0] total_entries;
  logic                  last;

  modport source (output valid, output col_index, output row_count, output row_end_offset,
                  output max_width, output total_entries, output last, input ready);
  modport sink   (input valid, input col_index, input row_count, input row_end_offset,
                  input max_width, input total_entries, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/dmsr_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on dmsr_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface dmsr_cfg_if;
  import dmsr_pkg::*;

  logic             valid;
  logic             ready;
  logic             index;
  logic [CNT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dmsr_col_scan.sv
// Column scanner: holds one row mask and walks its columns one per cycle while stepped.
// Shared by the count pass and the emit pass; depends on dmsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmsr_col_scan (
  input  wire                     clk,
  input  wire                     rst,
  input  wire dmsr_pkg::scan_ctl_t ctl,
  input  wire [dmsr_pkg::ROW_BITS-1:0] row,
  input  wire [dmsr_pkg::CNT_W-1:0]    lim,
  output dmsr_pkg::scan_stat_t    stat
);
  import dmsr_pkg::*;

  logic [ROW_BITS-1:0] row_q;
  logic [CNT_W-1:0]    lim_q;
  logic [CNT_W-1:0]    col;
  logic                done;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      row_q <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      lim_q <= '0;
    end else if (ctl.load) begin
      col   <= '0;
      lim_q <= lim;
    end else if (ctl.restart) begin
      col <= '0;
    end else if (ctl.step) begin
      col <= col + CNT_W'(1);
    end
  end

  // col stops at lim_q, which never exceeds ROW_BITS
  assign done      = (col == lim_q);
  assign stat.done = done;
  assign stat.col  = col[IDX_W-1:0];
  assign stat.hit  = row_q[col[IDX_W-1:0]] & ~done;

endmodule

`default_nettype wire

// File: hdl/dmsr_out_reg.sv
// Output register for the result channel; frees the sequencer from the sink.
// Depends on dmsr_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module dmsr_out_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  wire dmsr_pkg::result_t data,
  output logic                free,
  dmsr_out_if.source          res_out
);
  import dmsr_pkg::*;

  logic    valid;
  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  // a new beat may be loaded when the slot is empty or drains this cycle
  assign free = ~valid | res_out.ready;

  assign res_out.valid          = valid;
  assign res_out.col_index      = held.col_index;
  assign res_out.row_count      = held.row_count;
  assign res_out.row_end_offset = held.row_end_offset;
  assign res_out.max_width      = held.max_width;
  assign res_out.total_entries  = held.total_entries;
  assign res_out.last           = held.last;

endmodule

`default_nettype wire

// File: hdl/dense_mask_to_sparse_rows_unit.sv
// Dense mask to sparse rows converter. Takes one row mask per input beat and either
// clears the counters, measures the row (updates max width and total entries) or emits
// the row's active column indices in ascending order, in compressed-row form (each
// beat carries the running end offset) or itpack form (padded with -1 up to the
// measured width); a beat with the unused op code is dropped. One column scanner visits
// one column per cycle, a hit waiting until the output register is free, and examines
// only the columns in use (at most 32). A clear or a measure sends one report beat; an
// emit first counts the row, then scans it again and sends each active column up to
// the last one, or, when padding follows, scans every column and then sends the padding
// entries; an empty row with no padding sends one marker beat. The input is not ready
// until the item is done; the output register lets the last beat wait while the next
// item is taken. Depends on dmsr_pkg, the channel interfaces, dmsr_col_scan and
// dmsr_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module dense_mask_to_sparse_rows_unit #(
  parameter int MAX_COLS     = 32,
  parameter int OFFSET_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  dmsr_cfg_if.sink    cfg,
  dmsr_in_if.sink     row_in,
  dmsr_out_if.source  res_out
);
  import dmsr_pkg::*;

  localparam int COL_LIMIT = (MAX_COLS < ROW_BITS) ? MAX_COLS : ROW_BITS;
  localparam int OW = OFFSET_WIDTH;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COUNT = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;

  logic [2:0]       state, state_next;
  logic             layout_mode;
  logic [CNT_W-1:0] columns_in_use;
  logic [CNT_W-1:0] width_max, width_max_next;
  logic [OW-1:0]    entry_total, entry_total_next;
  logic [OW-1:0]    emit_offset, emit_offset_next;
  logic             op_emit, op_emit_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] total, total_next;
  logic [OW-1:0]    off, off_next;
  result_t          single, single_next;

  scan_ctl_t        scan_ctl;
  scan_stat_t       scan;
  logic [CNT_W-1:0] lim;
  logic             slot_free;
  logic             out_load;
  result_t          out_data;

  logic [OW:0]      et_sum, eo_sum;
  logic [OW-1:0]    et_sat, eo_sat;
  logic             is_last;

  // -------------------------------------------------------------- configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode    <= LAYOUT_CRS;
      columns_in_use <= COLUMNS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LAYOUT:  layout_mode    <= cfg.data[0];
        REG_COLUMNS: columns_in_use <= cfg.data;
      endcase
    end
  end

  assign lim = (columns_in_use > CNT_W'(COL_LIMIT)) ? CNT_W'(COL_LIMIT) : columns_in_use;

  // -------------------------------------------------------------- datapath
  dmsr_col_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (scan_ctl),
    .row  (row_in.row_mask),
    .lim  (lim),
    .stat (scan)
  );

  dmsr_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (out_load),
    .data    (out_data),
    .free    (slot_free),
    .res_out (res_out)
  );

  // saturate at all ones: cnt is small, so overflow shows as the carry bit
  assign et_sum  = {1'b0, entry_total} + (OW+1)'(cnt);
  assign eo_sum  = {1'b0, emit_offset} + (OW+1)'(cnt);
  assign et_sat  = et_sum[OW] ? {OW{1'b1}} : et_sum[OW-1:0];
  assign eo_sat  = eo_sum[OW] ? {OW{1'b1}} : eo_sum[OW-1:0];
  assign is_last = ((k + CNT_W'(1)) == total);

  assign row_in.ready = (state == ST_IDLE);

  // -------------------------------------------------------------- sequencer
  always_comb begin
    logic [OW-1:0]    off_v;
    logic [CNT_W-1:0] tot_v;

    state_next       = state;
    width_max_next   = width_max;
    entry_total_next = entry_total;
    emit_offset_next = emit_offset;
    op_emit_next     = op_emit;
    cnt_next         = cnt;
    k_next           = k;
    total_next       = total;
    off_next         = off;
    single_next      = single;
    scan_ctl         = '0;
    out_load         = 1'b0;
    out_data         = single;
    off_v            = '0;
    tot_v            = cnt;

    unique case (state)
      ST_IDLE: begin
        if (row_in.valid) begin
          unique case (row_in.op)
            OP_CLEAR: begin
              width_max_next   = '0;
              entry_total_next = '0;
              emit_offset_next = '0;
              single_next.col_index      = NEG_ONE;
              single_next.row_count      = '0;
              single_next.row_end_offset = '0;
              single_next.max_width      = '0;
              single_next.total_entries  = '0;
              single_next.last           = 1'b1;
              state_next = ST_SEND;
            end
            OP_MEASURE, OP_EMIT: begin
              scan_ctl.load = 1'b1;
              cnt_next      = '0;
              op_emit_next  = (row_in.op == OP_EMIT);
              state_next    = ST_COUNT;
            end
            default: ;  // unused op: drop the beat
          endcase
        end
      end

      ST_COUNT: begin
        if (!scan.done) begin
          cnt_next      = cnt + CNT_W'(scan.hit);
          scan_ctl.step = 1'b1;
        end else if (!op_emit) begin
          width_max_next   = (cnt > width_max) ? cnt : width_max;
          entry_total_next = et_sat;
          single_next.col_index      = NEG_ONE;
          single_next.row_count      = cnt;
          single_next.row_end_offset = PORT_OFF_W'(emit_offset);
          single_next.max_width      = width_max_next;
          single_next.total_entries  = PORT_OFF_W'(et_sat);
          single_next.last           = 1'b1;
          state_next = ST_SEND;
        end else begin
          if (layout_mode == LAYOUT_CRS) begin
            emit_offset_next = eo_sat;
            off_v            = eo_sat;
          end
          if (layout_mode == LAYOUT_ITPACK && width_max > cnt) begin
            tot_v = width_max;
          end
          off_next   = off_v;
          total_next = tot_v;
          k_next     = '0;
          if (tot_v == '0) begin
            // empty row: one marker beat
            single_next.col_index      = NEG_ONE;
            single_next.row_count      = '0;
            single_next.row_end_offset = PORT_OFF_W'(off_v);
            single_next.max_width      = width_max;
            single_next.total_entries  = PORT_OFF_W'(entry_total);
            single_next.last           = 1'b1;
            state_next = ST_SEND;
          end else begin
            scan_ctl.restart = 1'b1;
            state_next       = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        out_data.col_index      = CNT_W'(scan.col);
        out_data.row_count      = cnt;
        out_data.row_end_offset = PORT_OFF_W'(off);
        out_data.max_width      = width_max;
        out_data.total_entries  = PORT_OFF_W'(entry_total);
        out_data.last           = is_last;
        if (scan.done) begin
          state_next = (k == total) ? ST_IDLE : ST_PAD;
        end else if (!scan.hit) begin
          scan_ctl.step = 1'b1;
        end else if (slot_free) begin
          out_load      = 1'b1;
          scan_ctl.step = 1'b1;
          k_next        = k + CNT_W'(1);
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_PAD: begin
        out_data.col_index      = NEG_ONE;
        out_data.row_count      = cnt;
        out_data.row_end_offset = PORT_OFF_W'(off);
        out_data.max_width      = width_max;
        out_data.total_entries  = PORT_OFF_W'(entry_total);
        out_data.last           = is_last;
        if (slot_free) begin
          out_load = 1'b1;
          k_next   = k + CNT_W'(1);
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_SEND: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      width_max   <= '0;
      entry_total <= '0;
      emit_offset <= '0;
      op_emit     <= 1'b0;
      cnt         <= '0;
      k           <= '0;
      total       <= '0;
    end else begin
      state       <= state_next;
      width_max   <= width_max_next;
      entry_total <= entry_total_next;
      emit_offset <= emit_offset_next;
      op_emit     <= op_emit_next;
      cnt         <= cnt_next;
      k           <= k_next;
      total       <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    off    <= off_next;
    single <= single_next;
  end

endmodule

`default_nettype wire

// File: hdl/dmsr_checker.sv
// Port-level checks for dense_mask_to_sparse_rows_unit, attached by bind.
// Depends on dmsr_pkg for op codes and the -1 marker.
`timescale 1ns / 1ps
`default_nettype none

module dmsr_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire [1:0]                    op,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [dmsr_pkg::CNT_W-1:0]    col_index,
  input wire [dmsr_pkg::CNT_W-1:0]    row_count,
  input wire [dmsr_pkg::CNT_W-1:0]    max_width,
  input wire                          last
);
  import dmsr_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(col_index) && $stable(last)))
    else $error("result beat changed while stalled");

  // a measure or emit keeps the input closed while the row is scanned
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_MEASURE || op == OP_EMIT)) |=> !in_ready)
    else $error("input ready while a row is being scanned");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_count <= 6'd32 && max_width <= 6'd32))
    else $error("row count or max width out of range");

  // an emitted column index belongs to a row with entries
  a_index_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && col_index != NEG_ONE) |-> (row_count != '0))
    else $error("column index on a row counted empty");

endmodule

bind dense_mask_to_sparse_rows_unit dmsr_checker u_dmsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (row_in.valid),
  .in_ready  (row_in.ready),
  .op        (row_in.op),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .col_index (res_out.col_index),
  .row_count (res_out.row_count),
  .max_width (res_out.max_width),
  .last      (res_out.last)
);

`default_nettype wire

// File: test/dense_mask_to_sparse_rows_unit_tb.sv
// Self-checking bench for dense_mask_to_sparse_rows_unit: drives row beats and
// register writes, predicts every sparse entry and compares each result beat.
// Depends on dmsr_pkg, the three channel interfaces and the unit itself.
`timescale 1ns / 1ps

module dense_mask_to_sparse_rows_unit_tb;
  import dmsr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;      // longer than a full emit scan
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int RANDOM_ROWS = 120;
  localparam int SAT_PAIRS = 8;           // full measure/emit pairs at full rate

  // Tracks counters and configuration, and holds the sparse entries still owed.
  class sparse_row_scoreboard;
    bit                  layout = LAYOUT_CRS;
    bit [CNT_W-1:0]      columns = COLUMNS_RESET;
    bit [CNT_W-1:0]      width_max;
    bit [PORT_OFF_W-1:0] entry_total;
    bit [PORT_OFF_W-1:0] emit_offset;
    result_t             expected_entries[$];
    int                  mismatches;

    function void write_reg(logic idx, logic [CNT_W-1:0] val);
      if (idx == REG_LAYOUT) begin
        layout = val[0];
      end else begin
        columns = val;
      end
    endfunction

    function bit [PORT_OFF_W-1:0] sat_add(bit [PORT_OFF_W-1:0] a, int b);
      bit [PORT_OFF_W:0] s;
      s = {1'b0, a} + (PORT_OFF_W + 1)'(b);
      return s[PORT_OFF_W] ? {PORT_OFF_W{1'b1}} : s[PORT_OFF_W-1:0];
    endfunction

    function void push_entry(logic [CNT_W-1:0] col, int cnt, bit [PORT_OFF_W-1:0] off,
                             bit last);
      result_t e;
      e.col_index      = col;
      e.row_count      = CNT_W'(cnt);
      e.row_end_offset = off;
      e.max_width      = width_max;
      e.total_entries  = entry_total;
      e.last           = last;
      expected_entries.push_back(e);
    endfunction

    function void note_row(logic [1:0] op, logic [ROW_BITS-1:0] raw);
      bit [ROW_BITS-1:0]   mask;
      bit [PORT_OFF_W-1:0] off;
      int n;
      int cnt;
      int total;
      int k;
      n = (columns > ROW_BITS) ? ROW_BITS : columns;
      mask = (n >= ROW_BITS) ? raw : raw & ((32'd1 << n) - 32'd1);
      cnt = $countones(mask);
      case (op)
        OP_CLEAR: begin
          width_max = '0;
          entry_total = '0;
          emit_offset = '0;
          push_entry(NEG_ONE, 0, emit_offset, 1'b1);
        end
        OP_MEASURE: begin
          if (cnt > width_max) width_max = CNT_W'(cnt);
          entry_total = sat_add(entry_total, cnt);
          push_entry(NEG_ONE, cnt, emit_offset, 1'b1);
        end
        OP_EMIT: begin
          off = '0;
          if (layout == LAYOUT_CRS) begin
            emit_offset = sat_add(emit_offset, cnt);
            off = emit_offset;
          end
          total = cnt;
          if (layout == LAYOUT_ITPACK && width_max > total) total = width_max;
          if (total == 0) begin
            push_entry(NEG_ONE, 0, off, 1'b1);
          end else begin
            k = 0;
            for (int j = 0; j < ROW_BITS; j++) begin
              if (mask[j]) begin
                push_entry(CNT_W'(j), cnt, off, k + 1 == total);
                k++;
              end
            end
            // pad up to the measured width; a wider row gets no padding
            while (k < total) begin
              push_entry(NEG_ONE, cnt, off, k + 1 == total);
              k++;
            end
          end
        end
        default: ;  // unused code: drop
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_entry(result_t got);
      result_t want;
      if (expected_entries.size() == 0) begin
        report_mismatch("result beat with no entry pending");
        return;
      end
      want = expected_entries.pop_front();
      if (got.col_index !== want.col_index)
        report_mismatch($sformatf("col_index %h, want %h", got.col_index, want.col_index));
      if (got.row_count !== want.row_count)
        report_mismatch($sformatf("row_count %0d, want %0d", got.row_count, want.row_count));
      if (got.row_end_offset !== want.row_end_offset)
        report_mismatch($sformatf("row_end_offset %0d, want %0d",
                                  got.row_end_offset, want.row_end_offset));
      if (got.max_width !== want.max_width)
        report_mismatch($sformatf("max_width %0d, want %0d", got.max_width, want.max_width));
      if (got.total_entries !== want.total_entries)
        report_mismatch($sformatf("total_entries %0d, want %0d",
                                  got.total_entries, want.total_entries));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   steady;      // no idling on either side while set
  int   rows_sent;
  int   cycles;

  sparse_row_scoreboard sb = new;

  dmsr_cfg_if cfg();
  dmsr_in_if  row_in();
  dmsr_out_if res_out();

  dense_mask_to_sparse_rows_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .row_in  (row_in),
    .res_out (res_out)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Observe all three channels at the rising edge.
  always @(posedge clk) begin
    result_t beat;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (row_in.valid && row_in.ready) sb.note_row(row_in.op, row_in.row_mask);
      if (res_out.valid && res_out.ready) begin
        beat.col_index      = res_out.col_index;
        beat.row_count      = res_out.row_count;
        beat.row_end_offset = res_out.row_end_offset;
        beat.max_width      = res_out.max_width;
        beat.total_entries  = res_out.total_entries;
        beat.last           = res_out.last;
        sb.check_entry(beat);
      end
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  // Result side: stall a random number of cycles before taking each beat.
  initial begin
    int stall;
    res_out.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = idle_draw();
      @(negedge clk);
      if (stall != 0) begin
        res_out.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_out.ready = 1'b1;
      do @(posedge clk); while (!res_out.valid);
    end
  end

  task automatic send_row(logic [1:0] op, logic [ROW_BITS-1:0] mask);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      row_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_in.valid = 1'b1;
    row_in.op = op;
    row_in.row_mask = mask;
    do @(posedge clk); while (!row_in.ready);
    if (op != OP_UNUSED) rows_sent++;
  endtask

  // Hold input until every owed entry is back, then let a silent scan finish.
  task automatic settle();
    @(negedge clk);
    row_in.valid = 1'b0;
    while (sb.expected_entries.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(logic idx, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [ROW_BITS-1:0] random_mask();
    logic [ROW_BITS-1:0] m;
    m = '0;
    case ($urandom_range(0, 5))
      0: m = $urandom();
      1: m = 32'd1 << $urandom_range(0, 31);
      2: repeat ($urandom_range(1, 4)) m |= 32'd1 << $urandom_range(0, 31);
      3: begin
        repeat ($urandom_range(1, 4)) m |= 32'd1 << $urandom_range(0, 31);
        m = ~m;
      end
      4: m = $urandom_range(0, 1) ? '1 : '0;
      default: m = $urandom() & $urandom();
    endcase
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] random_columns();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd33;
      4: return 6'd63;
      default: return CNT_W'($urandom_range(2, 31));
    endcase
  endfunction

  initial begin
    logic [ROW_BITS-1:0] rows[$];
    int base;
    int n;
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_LAYOUT;
    cfg.data = '0;
    row_in.valid = 1'b0;
    row_in.op = OP_CLEAR;
    row_in.row_mask = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Compressed rows at reset settings: empty marker, full and edge rows, unused code.
    send_row(OP_EMIT, 32'h0);
    send_row(OP_MEASURE, 32'hFFFF_FFFF);
    send_row(OP_MEASURE, 32'h0);
    send_row(OP_MEASURE, 32'h1);
    send_row(OP_MEASURE, 32'h8000_0000);
    send_row(OP_EMIT, 32'hFFFF_FFFF);
    send_row(OP_EMIT, 32'h8000_0000);
    send_row(OP_EMIT, 32'h1);
    send_row(OP_EMIT, 32'h0);
    send_row(OP_UNUSED, 32'hDEAD_BEEF);
    send_row(OP_CLEAR, 32'h1234_5678);
    settle();

    // Padded rows: pure padding, a row wider than measured, partial padding, empty marker.
    set_register(REG_LAYOUT, CNT_W'(LAYOUT_ITPACK));
    send_row(OP_MEASURE, 32'h5);
    send_row(OP_EMIT, 32'h0);
    send_row(OP_EMIT, 32'hF);
    send_row(OP_EMIT, 32'h1);
    send_row(OP_CLEAR, 32'h0);
    send_row(OP_EMIT, 32'h0);
    settle();

    // No columns examined, then limits above the row width, then a single column.
    set_register(REG_COLUMNS, 6'd0);
    send_row(OP_MEASURE, 32'hFFFF_FFFF);
    send_row(OP_EMIT, 32'hFFFF_FFFF);
    settle();
    set_register(REG_COLUMNS, 6'd63);
    send_row(OP_MEASURE, 32'hFFFF_FFFF);
    send_row(OP_EMIT, 32'hAAAA_AAAA);
    settle();
    set_register(REG_COLUMNS, 6'd1);
    send_row(OP_EMIT, 32'hFFFF_FFFF);
    settle();
    set_register(REG_LAYOUT, CNT_W'(LAYOUT_CRS));
    set_register(REG_COLUMNS, 6'd33);
    send_row(OP_EMIT, 32'hFFFF_0000);
    settle();

    // Full rows back to back, no idling on either side.
    steady = 1'b1;
    set_register(REG_COLUMNS, 6'd32);
    send_row(OP_CLEAR, 32'h0);
    repeat (SAT_PAIRS) begin
      send_row(OP_MEASURE, 32'hFFFF_FFFF);
      send_row(OP_EMIT, 32'hFFFF_FFFF);
    end
    send_row(OP_MEASURE, 32'h7);
    settle();
    set_register(REG_LAYOUT, CNT_W'(LAYOUT_ITPACK));
    send_row(OP_EMIT, 32'h0);
    send_row(OP_CLEAR, 32'h0);
    settle();

    // Random phases: mostly clear / measure / emit sequences, some noise.
    base = rows_sent;
    while (rows_sent - base < RANDOM_ROWS) begin
      steady = ($urandom_range(0, 3) == 0);
      set_register(REG_LAYOUT,
                   CNT_W'($urandom_range(0, 1) ? LAYOUT_ITPACK : LAYOUT_CRS));
      set_register(REG_COLUMNS, random_columns());
      if ($urandom_range(0, 4) != 0) begin
        rows.delete();
        n = $urandom_range(1, 5);
        send_row(OP_CLEAR, $urandom());
        repeat (n) begin
          rows.push_back(random_mask());
          send_row(OP_MEASURE, rows[$]);
          if ($urandom_range(0, 9) == 0) send_row(OP_UNUSED, $urandom());
        end
        foreach (rows[i]) send_row(OP_EMIT, rows[i]);
        if ($urandom_range(0, 2) == 0) send_row(OP_EMIT, random_mask());
      end else begin
        repeat ($urandom_range(3, 8))
          send_row(2'($urandom_range(0, 3)), random_mask());
      end
      // pause until every owed entry is back before touching the registers
      settle();
    end

    if (sb.mismatches == 0 && sb.expected_entries.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: dense_mask_to_sparse_rows_unit.f
hdl/dmsr_pkg.sv
hdl/dmsr_in_if.sv
hdl/dmsr_out_if.sv
hdl/dmsr_cfg_if.sv
hdl/dmsr_col_scan.sv
hdl/dmsr_out_reg.sv
hdl/dense_mask_to_sparse_rows_unit.sv
hdl/dmsr_checker.sv
test/dense_mask_to_sparse_rows_unit_tb.sv
